@@ rtl/core/ape_pkg.sv @@
// Shared types, opcodes and the move-wide word builder for the AArch64 patch encoder.
`default_nettype none
package ape_pkg;

	typedef enum logic [3:0] {
		KIND_B       = 4'd0,
		KIND_BL      = 4'd1,
		KIND_CBZ     = 4'd2,
		KIND_CBNZ    = 4'd3,
		KIND_MOVZ    = 4'd4,
		KIND_MOVK    = 4'd5,
		KIND_MOVN    = 4'd6,
		KIND_MOV_REG = 4'd7,
		KIND_WIDE    = 4'd8
	} kind_t;

	localparam logic [31:0] OP_B     = 32'h1400_0000;
	localparam logic [31:0] OP_BL    = 32'h9400_0000;
	localparam logic [31:0] OP_CBZ   = 32'h3400_0000;
	localparam logic [31:0] OP_CBNZ  = 32'h3500_0000;
	localparam logic [31:0] SF_BIT   = 32'h8000_0000;
	localparam logic [31:0] ORR_XZR  = 32'hAA00_03E0;
	localparam logic [5:0]  MOVW_FAM = 6'h25;

	localparam logic [1:0] OPC_MOVN = 2'd0;
	localparam logic [1:0] OPC_MOVZ = 2'd2;
	localparam logic [1:0] OPC_MOVK = 2'd3;

	typedef struct packed {
		logic [3:0]  kind;
		logic [63:0] from_addr;
		logic [63:0] to_addr;
		logic [4:0]  reg_req;
		logic [4:0]  source_reg;
		logic        is_wide;
		logic [15:0] half_imm;
		logic [1:0]  half_shift;
		logic [63:0] wide_value;
	} req_t;

	typedef struct packed {
		logic [31:0] word;
		logic        ok;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] word;
		logic        more;
	} wide_out_t;

	function automatic logic [31:0] movw_word(input logic [1:0] opc, input logic [4:0] rd,
			input logic [15:0] imm16, input logic [1:0] hw);
		movw_word = {1'b1, opc, MOVW_FAM, hw, imm16, rd};
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/aarch64_patch_encoder_unit.sv @@
// Top level of the AArch64 patch encoder: input register, encoders, result register.
// The first word of a request passes through the input register and then the result register.
// Throughput: one word per cycle; single-word kinds accept a request every cycle while busy is low.
// A wide move holds the input register (busy high) while further words remain, 1 to 4 words.
// Results are strobed by valid for one cycle; the receiver cannot stall.
// Reset clears the input valid, the sequencer and the result strobe.
`default_nettype none
module aarch64_patch_encoder_unit (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           start,
	output logic          busy,
	input  ape_pkg::req_t req,
	output logic          valid,
	output ape_pkg::rsp_t rsp
);
	import ape_pkg::*;

	logic      accept;
	logic      valid_s1;
	req_t      req_s1;
	rsp_t      br_rsp;
	rsp_t      rsp_d;
	wide_out_t wout;
	logic      wide_en;

	assign wide_en = valid_s1 && (req_s1.kind == KIND_WIDE);
	assign busy    = wide_en && wout.more;
	assign accept  = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || busy;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	ape_branch_enc u_branch (
		.req (req_s1),
		.rsp (br_rsp)
	);

	ape_wide_seq u_wide (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (wide_en),
		.value  (req_s1.wide_value),
		.rd     (req_s1.reg_req),
		.wout   (wout)
	);

	always_comb begin
		rsp_d.ok   = 1'b1;
		rsp_d.last = 1'b1;
		case (req_s1.kind)
			KIND_B, KIND_BL, KIND_CBZ, KIND_CBNZ: begin
				rsp_d = br_rsp;
			end
			KIND_MOVZ: begin
				rsp_d.word = movw_word(OPC_MOVZ, req_s1.reg_req, req_s1.half_imm,
					req_s1.half_shift);
			end
			KIND_MOVK: begin
				rsp_d.word = movw_word(OPC_MOVK, req_s1.reg_req, req_s1.half_imm,
					req_s1.half_shift);
			end
			KIND_MOVN: begin
				rsp_d.word = movw_word(OPC_MOVN, req_s1.reg_req, req_s1.half_imm,
					req_s1.half_shift);
			end
			KIND_MOV_REG: begin
				rsp_d.word = ORR_XZR | {11'b0, req_s1.source_reg, 11'b0, req_s1.reg_req};
			end
			KIND_WIDE: begin
				rsp_d.word = wout.word;
				rsp_d.last = !wout.more;
			end
			default: begin
				rsp_d.word = 32'h0;
				rsp_d.ok   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else begin
			valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp <= rsp_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/ape_branch_enc.sv @@
// Branch encoder: alignment and range checks, B/BL and CBZ/CBNZ words.
`default_nettype none
module ape_branch_enc (
	input  ape_pkg::req_t req,
	output ape_pkg::rsp_t rsp
);
	import ape_pkg::*;

	logic [63:0] diff;
	logic        aligned;
	logic        long_ok;
	logic        short_ok;
	logic        is_cb;
	logic        pass;
	logic [31:0] word_b;
	logic [31:0] word_cb;

	assign diff     = req.to_addr - req.from_addr;
	assign aligned  = (req.from_addr[1:0] == 2'b00) && (req.to_addr[1:0] == 2'b00);
	assign long_ok  = (diff[63:27] == '0) || (diff[63:27] == '1);
	assign short_ok = (diff[63:20] == '0) || (diff[63:20] == '1);
	assign is_cb    = (req.kind == KIND_CBZ) || (req.kind == KIND_CBNZ);
	assign pass     = aligned && (is_cb ? short_ok : long_ok);

	assign word_b  = ((req.kind == KIND_BL) ? OP_BL : OP_B) | {6'b0, diff[27:2]};
	assign word_cb = ((req.kind == KIND_CBNZ) ? OP_CBNZ : OP_CBZ)
		| (req.is_wide ? SF_BIT : 32'h0) | {8'b0, diff[20:2], req.reg_req};

	always_comb begin
		rsp.ok   = pass;
		rsp.last = 1'b1;
		rsp.word = pass ? (is_cb ? word_cb : word_b) : 32'h0;
	end

endmodule
`default_nettype wire

@@ rtl/core/ape_wide_seq.sv @@
// Wide move sequencer: one MOVZ/MOVK word per cycle while en is high, over nonzero halfwords (one MOVZ #0 if none).
`default_nettype none
module ape_wide_seq (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  wire  [63:0]         value,
	input  wire  [4:0]          rd,
	output ape_pkg::wide_out_t  wout
);
	import ape_pkg::*;

	logic       cont_q;
	logic [3:0] pend_q;
	logic [3:0] nz;
	logic [3:0] mask;
	logic [3:0] rest;
	logic [1:0] idx;
	logic [15:0] chunk;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			nz[i] = (value[16*i +: 16] != 16'h0);
		end
	end

	assign mask = cont_q ? pend_q : nz;

	always_comb begin
		idx = 2'd0;
		for (int i = 3; i >= 0; i--) begin
			if (mask[i]) begin
				idx = 2'(i);
			end
		end
	end

	assign chunk     = value[{idx, 4'b0000} +: 16];
	assign rest      = mask & (mask - 4'd1);
	assign wout.more = (rest != 4'd0);
	assign wout.word = movw_word(cont_q ? OPC_MOVK : OPC_MOVZ, rd, chunk, idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_q <= 1'b0;
		end else if (en) begin
			cont_q <= wout.more;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pend_q <= rest;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/ape_checker.sv @@
// Port-level checker for the patch encoder, bound to the top level.
`default_nettype none
module ape_checker (
	input wire           clk,
	input wire           arst_n,
	input wire           start,
	input wire           busy,
	input ape_pkg::rsp_t rsp,
	input wire           valid
);
	import ape_pkg::*;

	a_busy_gives_more: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> valid && !rsp.last)
		else $error("busy without a following non-final word");

	a_transfer_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 valid)
		else $error("no result two cycles after transfer");

	a_fail_is_single_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !rsp.ok |-> rsp.word == 32'h0 && rsp.last)
		else $error("failed result not a single zero word");

	a_multi_word_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !rsp.last |-> rsp.ok)
		else $error("non-final word without ok");

endmodule

bind aarch64_patch_encoder_unit ape_checker u_ape_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.rsp    (rsp),
	.valid  (valid)
);
`default_nettype wire

@@ dv/patch_word_checker.sv @@
// Checker for the patch encoder: predicts the instruction words of each transfer and compares results.
`timescale 1ns / 1ps
module patch_word_checker (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire                   busy,
	input  ape_pkg::req_t         req,
	input  wire                   valid,
	input  ape_pkg::rsp_t         rsp,
	output int                    mismatch_count,
	output int                    words_outstanding
);
	import ape_pkg::*;

	rsp_t expected_words [$];
	rsp_t want;

	task automatic report_mismatch(input string what);
		$display("ERROR %0t ns: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic void push_word(input logic [31:0] w, input logic ok, input logic last);
		rsp_t e;
		e.word = w;
		e.ok   = ok;
		e.last = last;
		expected_words.insert(expected_words.size(), e);
	endfunction

	function automatic logic fits(input logic [63:0] diff, input logic [63:0] lim);
		return (diff + lim) < (lim << 1);
	endfunction

	function automatic logic [31:0] move_wide_word(input logic [1:0] opc, input logic [4:0] rd,
			input logic [15:0] imm, input logic [1:0] hw);
		return {1'b1, opc, MOVW_FAM, hw, imm, rd};
	endfunction

	function automatic void predict_words(input req_t r);
		logic [63:0] diff;
		logic        aligned;
		logic [15:0] chunk;
		logic [31:0] seq [$];
		diff = r.to_addr - r.from_addr;
		aligned = (r.from_addr[1:0] == 2'b00) && (r.to_addr[1:0] == 2'b00);
		case (r.kind)
			KIND_B, KIND_BL: begin
				if (aligned && fits(diff, 64'd1 << 27))
					push_word((r.kind == KIND_B ? OP_B : OP_BL) | {6'd0, diff[27:2]}, 1'b1, 1'b1);
				else
					push_word('0, 1'b0, 1'b1);
			end
			KIND_CBZ, KIND_CBNZ: begin
				if (aligned && fits(diff, 64'd1 << 20))
					push_word((r.kind == KIND_CBZ ? OP_CBZ : OP_CBNZ) |
						(r.is_wide ? SF_BIT : 32'd0) | {8'd0, diff[20:2], r.reg_req},
						1'b1, 1'b1);
				else
					push_word('0, 1'b0, 1'b1);
			end
			KIND_MOVZ:
				push_word(move_wide_word(OPC_MOVZ, r.reg_req, r.half_imm, r.half_shift), 1'b1, 1'b1);
			KIND_MOVK:
				push_word(move_wide_word(OPC_MOVK, r.reg_req, r.half_imm, r.half_shift), 1'b1, 1'b1);
			KIND_MOVN:
				push_word(move_wide_word(OPC_MOVN, r.reg_req, r.half_imm, r.half_shift), 1'b1, 1'b1);
			KIND_MOV_REG:
				push_word(ORR_XZR | {11'd0, r.source_reg, 11'd0, r.reg_req}, 1'b1, 1'b1);
			KIND_WIDE: begin
				for (int s = 0; s < 4; s++) begin
					chunk = r.wide_value[s*16 +: 16];
					if (chunk != 16'd0)
						seq.insert(seq.size(), move_wide_word(seq.size() == 0 ? OPC_MOVZ : OPC_MOVK,
							r.reg_req, chunk, 2'(s)));
				end
				if (seq.size() == 0)
					seq.insert(0, move_wide_word(OPC_MOVZ, r.reg_req, 16'd0, 2'd0));
				for (int i = 0; i < seq.size(); i++)
					push_word(seq[i], 1'b1, i == seq.size() - 1);
			end
			default:
				push_word('0, 1'b0, 1'b1);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			mismatch_count = 0;
		end else begin
			if (start && !busy)
				predict_words(req);
			if (valid) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("word %h with no request pending", rsp.word));
				end else begin
					want = expected_words.pop_front();
					if (rsp.word !== want.word)
						report_mismatch($sformatf("word %h, want %h", rsp.word, want.word));
					if (rsp.ok !== want.ok)
						report_mismatch($sformatf("ok %b, want %b (word %h)", rsp.ok, want.ok,
							want.word));
					if (rsp.last !== want.last)
						report_mismatch($sformatf("last %b, want %b (word %h)", rsp.last,
							want.last, want.word));
				end
			end
		end
		words_outstanding = expected_words.size();
	end

endmodule

@@ dv/aarch64_patch_encoder_unit_tb.sv @@
// Testbench top for the patch encoder: clock, reset, directed and random requests, verdict.
`timescale 1ns / 1ps
module aarch64_patch_encoder_unit_tb;
	import ape_pkg::*;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic calm   = 1'b0;
	logic busy;
	logic valid;
	rsp_t rsp;
	int   mismatch_count;
	int   words_outstanding;

	kind_t branch_kinds [4] = '{KIND_B, KIND_BL, KIND_CBZ, KIND_CBNZ};
	kind_t move_kinds   [3] = '{KIND_MOVZ, KIND_MOVK, KIND_MOVN};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	aarch64_patch_encoder_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.valid  (valid),
		.rsp    (rsp)
	);

	patch_word_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.req               (req),
		.valid             (valid),
		.rsp               (rsp),
		.mismatch_count    (mismatch_count),
		.words_outstanding (words_outstanding)
	);

	function automatic req_t random_request();
		req_t r;
		r.kind       = 4'($urandom);
		r.from_addr  = {$urandom, $urandom};
		r.to_addr    = {$urandom, $urandom};
		r.reg_req    = 5'($urandom);
		r.source_reg = 5'($urandom);
		r.is_wide    = 1'($urandom);
		r.half_imm   = 16'($urandom);
		r.half_shift = 2'($urandom);
		r.wide_value = {$urandom, $urandom};
		return r;
	endfunction

	function automatic req_t branch_req(input kind_t k, input logic [63:0] from,
			input logic [63:0] off);
		req_t r;
		r = random_request();
		r.kind      = k;
		r.from_addr = from;
		r.to_addr   = from + off;
		return r;
	endfunction

	function automatic req_t move_req(input kind_t k, input logic [4:0] rd,
			input logic [15:0] imm, input logic [1:0] hw);
		req_t r;
		r = random_request();
		r.kind       = k;
		r.reg_req    = rd;
		r.source_reg = ~rd;
		r.half_imm   = imm;
		r.half_shift = hw;
		return r;
	endfunction

	function automatic req_t wide_req(input logic [4:0] rd, input logic [63:0] value);
		req_t r;
		r = random_request();
		r.kind       = KIND_WIDE;
		r.reg_req    = rd;
		r.wide_value = value;
		return r;
	endfunction

	function automatic req_t random_branch();
		req_t        r;
		logic [63:0] lim;
		logic [63:0] off;
		int          pick;
		r = random_request();
		r.kind = branch_kinds[$urandom_range(3)];
		lim = (r.kind inside {KIND_B, KIND_BL}) ? 64'd1 << 27 : 64'd1 << 20;
		r.from_addr[1:0] = 2'b00;
		pick = $urandom_range(99);
		if (pick < 10)
			off = -lim;
		else if (pick < 20)
			off = lim - 64'd4;
		else if (pick < 75)
			off = ({$urandom, $urandom} % (lim << 1)) - lim;
		else if (pick < 82)
			off = $urandom_range(1) ? lim : -lim - 64'd4;
		else
			off = {$urandom, $urandom};
		off[1:0] = 2'b00;
		r.to_addr = r.from_addr + off;
		if (pick >= 90) begin
			if ($urandom_range(1))
				r.to_addr[1:0] = 2'($urandom_range(1, 3));
			else
				r.from_addr[1:0] = 2'($urandom_range(1, 3));
		end
		return r;
	endfunction

	function automatic req_t random_wide();
		req_t r;
		r = random_request();
		r.kind = KIND_WIDE;
		for (int s = 0; s < 4; s++) begin
			if ($urandom_range(99) < 40)
				r.wide_value[s*16 +: 16] = 16'd0;
			else if ($urandom_range(99) < 10)
				r.wide_value[s*16 +: 16] = 16'hFFFF;
		end
		return r;
	endfunction

	task automatic send_request(input req_t r);
		while (!calm && $urandom_range(99) < 34) begin
			start <= 1'b0;
			req   <= random_request();
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		req_t r;
		int   pick;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(branch_req(KIND_B, 64'h1000_0000, (64'd1 << 27) - 64'd4));
		send_request(branch_req(KIND_BL, 64'h4000_0000, -(64'd1 << 27)));
		send_request(branch_req(KIND_B, 64'h4000_0000, 64'd1 << 27));
		send_request(branch_req(KIND_BL, 64'hFFFF_FFFF_FFFF_FFFC, 64'd8));
		send_request(branch_req(KIND_B, 64'h2000_0002, 64'd4));
		send_request(branch_req(KIND_BL, 64'h2000_0000, 64'd3));
		send_request(branch_req(KIND_CBZ, 64'h8000, (64'd1 << 20) - 64'd4));
		send_request(branch_req(KIND_CBNZ, 64'h0, -(64'd1 << 20)));
		send_request(branch_req(KIND_CBZ, 64'h10_0000, -(64'd1 << 20) - 64'd4));
		send_request(branch_req(KIND_CBNZ, 64'h10_0000, 64'd1 << 20));
		send_request(branch_req(KIND_CBNZ, 64'h10_0001, 64'd0));
		send_request(move_req(KIND_MOVZ, 5'd31, 16'hFFFF, 2'd3));
		send_request(move_req(KIND_MOVK, 5'd0, 16'h0000, 2'd0));
		send_request(move_req(KIND_MOVN, 5'd9, 16'h8001, 2'd1));
		send_request(move_req(KIND_MOVZ, 5'd17, 16'h0000, 2'd2));
		send_request(move_req(KIND_MOV_REG, 5'd0, 16'h0000, 2'd0));
		send_request(move_req(KIND_MOV_REG, 5'd31, 16'h0000, 2'd0));
		send_request(wide_req(5'd1, 64'd0));
		send_request(wide_req(5'd31, 64'hFFFF_FFFF_FFFF_FFFF));
		send_request(wide_req(5'd2, 64'hFFFF_0000_0000_0000));
		send_request(wide_req(5'd3, 64'h0000_1234_0000_5678));
		send_request(wide_req(5'd4, 64'h0000_0000_0001_0000));
		r = random_request();
		r.kind = KIND_WIDE + 4'd1;
		send_request(r);
		r = random_request();
		r.kind = KIND_WIDE + 4'd7;
		send_request(r);

		for (int n = 0; n < 350; n++) begin
			calm = (n >= 150 && n < 230);
			pick = $urandom_range(99);
			if (pick < 35) begin
				send_request(random_branch());
			end else if (pick < 55) begin
				r = random_request();
				r.kind = move_kinds[$urandom_range(2)];
				send_request(r);
			end else if (pick < 63) begin
				r = random_request();
				r.kind = KIND_MOV_REG;
				send_request(r);
			end else if (pick < 93) begin
				send_request(random_wide());
			end else begin
				r = random_request();
				r.kind = KIND_WIDE + 4'($urandom_range(1, 7));
				send_request(r);
			end
		end
		start <= 1'b0;

		for (int i = 0; i < 200 && words_outstanding != 0; i++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && words_outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#200000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/ape_pkg.sv
rtl/core/ape_branch_enc.sv
rtl/core/ape_wide_seq.sv
rtl/core/aarch64_patch_encoder_unit.sv
rtl/core/ape_checker.sv
dv/patch_word_checker.sv
dv/aarch64_patch_encoder_unit_tb.sv
